// File: rtl/icv_pkg.sv
`default_nettype none

package icv_pkg;

    localparam int unsigned HEADER_BYTES = 64;
    localparam int unsigned COUNT_BYTES  = 16;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [31:0] HASH_PRIME    = 32'h0100_0193;
    localparam logic [31:0] HASH_BASIS    = 32'h811C_9DC5;
    localparam logic [63:0] MAGIC_RESET   = 64'h4741_524E_4445_4141;
    localparam logic [31:0] VERSION_RESET = 32'd2;

    localparam int unsigned ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_MAGIC   = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_VERSION = 4'h8;

    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_SHORT_HEADER = 4'd1,
        ST_MAGIC        = 4'd2,
        ST_VERSION      = 4'd3,
        ST_LENGTH       = 4'd4,
        ST_EMPTY        = 4'd5,
        ST_CHECKSUM     = 4'd6,
        ST_SHORT_COUNTS = 4'd7,
        ST_SIZE         = 4'd8
    } icv_status_t;

    // Everything the checks need about one finished file.
    typedef struct packed {
        logic [63:0]       total;
        logic [63:0]       magic;
        logic [31:0]       version;
        logic [63:0]       declared;
        logic [31:0]       checksum;
        logic [31:0]       hash;
        logic [3:0][31:0]  counts;
    } icv_record_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * HASH_PRIME;
    endfunction

endpackage

`default_nettype wire

// File: rtl/icv_in_if.sv
`default_nettype none

interface icv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/icv_out_if.sv
`default_nettype none

interface icv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [31:0] token_count;
    logic [31:0] dimension_count;
    logic [31:0] centroid_count;
    logic [31:0] token_stride_out;
    logic [31:0] checksum_out;

    modport source (output valid, output status, output token_count,
                    output dimension_count, output centroid_count,
                    output token_stride_out, output checksum_out, input ready);
    modport sink   (input valid, input status, input token_count,
                    input dimension_count, input centroid_count,
                    input token_stride_out, input checksum_out, output ready);
endinterface

`default_nettype wire

// File: rtl/icv_front.sv
`default_nettype none

module icv_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    icv_in_if.sink             stream,
    input  wire logic          q_full,
    output icv_pkg::icv_record_t rec,
    output logic               push
);

    logic [63:0]      pos_reg, pos_next, pos_upd;
    logic [63:0]      magic_reg, magic_next, magic_upd;
    logic [31:0]      version_reg, version_next, version_upd;
    logic [63:0]      declared_reg, declared_next, declared_upd;
    logic [31:0]      checksum_reg, checksum_next, checksum_upd;
    logic [31:0]      hash_reg, hash_next, hash_upd;
    logic [3:0][31:0] counts_reg, counts_next, counts_upd;

    logic       accept;
    logic       hdr;
    logic       cap;
    logic [5:0] idx;
    logic [5:0] dl_off;
    logic [7:0] b;

    assign stream.ready = !q_full;
    assign accept       = stream.valid && stream.ready;
    assign push         = accept && stream.last_byte;
    assign b            = stream.data_byte;

    always_comb
    begin
        idx    = pos_reg[5:0];
        hdr    = (pos_reg[63:6] == 58'd0);
        dl_off = idx - 6'd12;
        // first sixteen payload bytes: positions 64..79
        cap    = (pos_reg[63:4] == 60'd4);

        magic_upd    = magic_reg;
        version_upd  = version_reg;
        declared_upd = declared_reg;
        checksum_upd = checksum_reg;
        counts_upd   = counts_reg;

        for (int k = 0; k < 8; k++)
        begin
            if (hdr && idx[5:3] == 3'd0 && idx[2:0] == 3'(k))
                magic_upd[8*k +: 8] = magic_reg[8*k +: 8] | b;
            if (hdr && idx >= 6'd12 && idx < 6'd20 && dl_off[2:0] == 3'(k))
                declared_upd[8*k +: 8] = declared_reg[8*k +: 8] | b;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (hdr && idx[5:2] == 4'd2 && idx[1:0] == 2'(k))
                version_upd[8*k +: 8] = version_reg[8*k +: 8] | b;
            if (hdr && idx[5:2] == 4'd5 && idx[1:0] == 2'(k))
                checksum_upd[8*k +: 8] = checksum_reg[8*k +: 8] | b;
        end
        for (int w = 0; w < 4; w++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (cap && pos_reg[3:2] == 2'(w) && pos_reg[1:0] == 2'(k))
                    counts_upd[w][8*k +: 8] = counts_reg[w][8*k +: 8] | b;
            end
        end

        hash_upd = hdr ? hash_reg : icv_pkg::fnv_step(hash_reg, b);
        // saturate on a very long file
        pos_upd  = (&pos_reg) ? pos_reg : pos_reg + 64'd1;
    end

    always_comb
    begin
        rec.total    = pos_upd;
        rec.magic    = magic_upd;
        rec.version  = version_upd;
        rec.declared = declared_upd;
        rec.checksum = checksum_upd;
        rec.hash     = hash_upd;
        rec.counts   = counts_upd;
    end

    always_comb
    begin
        pos_next      = pos_reg;
        magic_next    = magic_reg;
        version_next  = version_reg;
        declared_next = declared_reg;
        checksum_next = checksum_reg;
        hash_next     = hash_reg;
        counts_next   = counts_reg;
        if (accept)
        begin
            if (stream.last_byte)
            begin
                // drop per-file state, next byte opens a new file
                pos_next      = 64'd0;
                magic_next    = 64'd0;
                version_next  = 32'd0;
                declared_next = 64'd0;
                checksum_next = 32'd0;
                hash_next     = icv_pkg::HASH_BASIS;
                counts_next   = '0;
            end
            else
            begin
                pos_next      = pos_upd;
                magic_next    = magic_upd;
                version_next  = version_upd;
                declared_next = declared_upd;
                checksum_next = checksum_upd;
                hash_next     = hash_upd;
                counts_next   = counts_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= 64'd0;
            magic_reg    <= 64'd0;
            version_reg  <= 32'd0;
            declared_reg <= 64'd0;
            checksum_reg <= 32'd0;
            hash_reg     <= icv_pkg::HASH_BASIS;
            counts_reg   <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            magic_reg    <= magic_next;
            version_reg  <= version_next;
            declared_reg <= declared_next;
            checksum_reg <= checksum_next;
            hash_reg     <= hash_next;
            counts_reg   <= counts_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/icv_queue.sv
`default_nettype none

module icv_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire icv_pkg::icv_record_t push_data,
    output logic                      full,
    input  wire logic                 pop,
    output icv_pkg::icv_record_t      pop_data,
    output logic                      empty
);

    localparam int unsigned PTR_W = (icv_pkg::QUEUE_DEPTH > 1) ? $clog2(icv_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(icv_pkg::QUEUE_DEPTH + 1);

    icv_pkg::icv_record_t entry_reg [icv_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(icv_pkg::QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(icv_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/icv_back.sv
`default_nettype none

module icv_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire icv_pkg::icv_record_t rec,
    input  wire logic                 rec_valid,
    output logic                      rec_pop,
    input  wire logic [63:0]          magic_word,
    input  wire logic [31:0]          version_word,
    icv_out_if.source                 result
);

    // stage 1: ordered checks and the size products
    logic                 s1_valid_reg, s1_valid_next;
    icv_pkg::icv_status_t s1_status_reg, s1_status_next;
    logic [63:0]          s1_cd_reg, s1_ts_reg;
    logic [63:0]          s1_plen_reg;
    logic [3:0][31:0]     s1_counts_reg;
    logic [31:0]          s1_checksum_reg;

    // stage 2: output register
    logic                 out_valid_reg, out_valid_next;
    icv_pkg::icv_status_t out_status_reg, out_status_next;
    logic [3:0][31:0]     out_counts_reg;
    logic [31:0]          out_checksum_reg;

    logic        load_out;
    logic        s1_ready;
    logic [63:0] plen;
    logic [63:0] want;
    logic        pass;

    assign load_out = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_ready = !s1_valid_reg || load_out;
    assign rec_pop  = rec_valid && s1_ready;
    assign plen     = rec.total - 64'(icv_pkg::HEADER_BYTES);

    always_comb
    begin
        priority if (rec.total < 64'(icv_pkg::HEADER_BYTES))
            s1_status_next = icv_pkg::ST_SHORT_HEADER;
        else if (rec.magic != magic_word)
            s1_status_next = icv_pkg::ST_MAGIC;
        else if (rec.version != version_word)
            s1_status_next = icv_pkg::ST_VERSION;
        else if (plen != rec.declared)
            s1_status_next = icv_pkg::ST_LENGTH;
        else if (rec.declared == 64'd0)
            s1_status_next = icv_pkg::ST_EMPTY;
        else if (rec.hash != rec.checksum)
            s1_status_next = icv_pkg::ST_CHECKSUM;
        else if (plen < 64'(icv_pkg::COUNT_BYTES))
            s1_status_next = icv_pkg::ST_SHORT_COUNTS;
        else
            s1_status_next = icv_pkg::ST_OK;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rec_pop)
            s1_valid_next = 1'b1;
        else if (load_out)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rec_pop)
        begin
            s1_status_reg   <= s1_status_next;
            s1_cd_reg       <= {32'd0, rec.counts[2]} * {32'd0, rec.counts[1]};
            s1_ts_reg       <= {32'd0, rec.counts[0]} * {32'd0, rec.counts[3]};
            s1_plen_reg     <= plen;
            s1_counts_reg   <= rec.counts;
            s1_checksum_reg <= rec.checksum;
        end
    end

    // size: 16 + 4*centroids*dims + 4*centroids + tokens*stride, modulo 2^64
    always_comb
    begin
        want = 64'(icv_pkg::COUNT_BYTES) + {s1_cd_reg[61:0], 2'b00}
             + {30'd0, s1_counts_reg[2], 2'b00} + s1_ts_reg;
        if (s1_status_reg == icv_pkg::ST_OK && want != s1_plen_reg)
            out_status_next = icv_pkg::ST_SIZE;
        else
            out_status_next = s1_status_reg;
        pass = (out_status_next == icv_pkg::ST_OK);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg   <= out_status_next;
            out_counts_reg   <= pass ? s1_counts_reg : '0;
            out_checksum_reg <= pass ? s1_checksum_reg : 32'd0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.token_count      = out_counts_reg[0];
    assign result.dimension_count  = out_counts_reg[1];
    assign result.centroid_count   = out_counts_reg[2];
    assign result.token_stride_out = out_counts_reg[3];
    assign result.checksum_out     = out_checksum_reg;

endmodule

`default_nettype wire

// File: rtl/index_container_validator_top.sv
// Index container validator.
// stream: one byte of the container file per transfer (data_byte), with
//   last_byte high on the final byte. Header bytes 0..63 hold magic,
//   version, payload length and payload checksum; the rest is payload,
//   hashed with 32-bit FNV-1a and whose first 16 bytes are four counts.
// result: one transfer per file, carrying the status of the first failing
//   check and the counts and checksum (zero unless status is ok).
// APB port: magic word at address 0x0 (64 bit), format version at 0x8.
//   Writes land on the access cycle; write only while no file is in flight.
// Throughput: one byte per cycle while the queue is not full, set by the
//   combinational hash update in the front end. Path: the last byte's record
//   is written into the queue on the edge that transfers that byte, then
//   passes the check/multiply stage and then the output register.
// Stall: a stalled result holds in the output register; the two-entry queue
//   between front and back absorbs finished files, and stream.ready drops
//   only when that queue is full.
// Reset: per-file state clears, the hash returns to its offset basis and the
//   registers return to their defaults; no result is pending.
`default_nettype none

module index_container_validator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    icv_in_if.sink                           stream,
    icv_out_if.source                        result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [icv_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);

    logic [63:0] magic_reg, magic_next;
    logic [31:0] version_reg, version_next;
    logic        cfg_wr;

    icv_pkg::icv_record_t front_rec;
    icv_pkg::icv_record_t back_rec;
    logic                 push;
    logic                 q_full;
    logic                 q_empty;
    logic                 pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Register writes; unknown addresses drop the write.
    always_comb
    begin
        magic_next   = magic_reg;
        version_next = version_reg;
        if (cfg_wr)
        begin
            if (paddr == icv_pkg::ADDR_MAGIC)
                magic_next = pwdata;
            else if (paddr == icv_pkg::ADDR_VERSION)
                version_next = pwdata[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= icv_pkg::MAGIC_RESET;
            version_reg <= icv_pkg::VERSION_RESET;
        end
        else
        begin
            magic_reg   <= magic_next;
            version_reg <= version_next;
        end
    end

    always_comb
    begin
        if (paddr == icv_pkg::ADDR_MAGIC)
            prdata = magic_reg;
        else if (paddr == icv_pkg::ADDR_VERSION)
            prdata = {32'd0, version_reg};
        else
            prdata = 64'd0;
    end

    // Front: collect header fields, hash payload, push a record per file.
    icv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream),
        .q_full (q_full),
        .rec    (front_rec),
        .push   (push)
    );

    // Hold finished files until the back end takes them.
    icv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_rec),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (back_rec),
        .empty     (q_empty)
    );

    // Back: run the ordered checks and drive the result channel.
    icv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rec          (back_rec),
        .rec_valid    (!q_empty),
        .rec_pop      (pop),
        .magic_word   (magic_reg),
        .version_word (version_reg),
        .result       (result)
    );

endmodule

`default_nettype wire

// File: verif/tb_index_container_validator_top.sv
module tb_index_container_validator_top;

    // One finished file as the result channel reports it.
    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] tokens;
        logic [31:0] dims;
        logic [31:0] centroids;
        logic [31:0] stride;
        logic [31:0] checksum;
    } file_verdict_t;

    // Ways a generated container can be spoiled on purpose.
    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_VERSION,
        FLT_LENGTH,
        FLT_CHECKSUM,
        FLT_SIZE,
        FLT_TRUNC
    } container_fault_t;

    // Patterns the result side cycles through when it is not held off.
    typedef enum int {
        RX_STEADY,
        RX_MOSTLY,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_mode_t;

    localparam int RESET_CYCLES   = 3;
    localparam int RANDOM_BYTES   = 700;
    localparam int RANDOM_FILES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RUN_LIMIT      = 5_000_000;

    // Tracks the per-file header/payload state and the expected verdicts.
    class container_scoreboard;
        logic [63:0]   magic_cfg;
        logic [31:0]   version_cfg;
        logic [63:0]   pos;
        logic [63:0]   magic_acc;
        logic [31:0]   version_acc;
        logic [63:0]   declared_acc;
        logic [31:0]   checksum_acc;
        logic [31:0]   hash_acc;
        logic [31:0]   counts [4];
        file_verdict_t pending [$];
        int            failures;

        function new();
            magic_cfg   = icv_pkg::MAGIC_RESET;
            version_cfg = icv_pkg::VERSION_RESET;
            failures    = 0;
            clear_file();
        endfunction

        function void clear_file();
            pos          = '0;
            magic_acc    = '0;
            version_acc  = '0;
            declared_acc = '0;
            checksum_acc = '0;
            hash_acc     = icv_pkg::HASH_BASIS;
            foreach (counts[k]) counts[k] = '0;
        endfunction

        static function logic [63:0] layout_size(logic [31:0] tok, logic [31:0] dim,
                                                 logic [31:0] cen, logic [31:0] stride);
            // All terms are 64 bits wide, so products and sum wrap modulo 2^64.
            return 64'(icv_pkg::COUNT_BYTES)
                 + {32'd0, cen} * {32'd0, dim} * 64'd4
                 + {32'd0, cen} * 64'd4
                 + {32'd0, tok} * {32'd0, stride};
        endfunction

        function icv_pkg::icv_status_t judge();
            logic [63:0] plen;
            if (pos < 64'(icv_pkg::HEADER_BYTES)) return icv_pkg::ST_SHORT_HEADER;
            if (magic_acc != magic_cfg) return icv_pkg::ST_MAGIC;
            if (version_acc != version_cfg) return icv_pkg::ST_VERSION;
            plen = pos - 64'(icv_pkg::HEADER_BYTES);
            if (plen != declared_acc) return icv_pkg::ST_LENGTH;
            if (declared_acc == '0) return icv_pkg::ST_EMPTY;
            if (hash_acc != checksum_acc) return icv_pkg::ST_CHECKSUM;
            if (plen < 64'(icv_pkg::COUNT_BYTES)) return icv_pkg::ST_SHORT_COUNTS;
            if (layout_size(counts[0], counts[1], counts[2], counts[3]) != plen)
                return icv_pkg::ST_SIZE;
            return icv_pkg::ST_OK;
        endfunction

        // Fold one accepted byte into the file state; queue a verdict on the last one.
        function void note_byte(logic [7:0] b, logic last);
            file_verdict_t        v;
            icv_pkg::icv_status_t st;
            logic [63:0]          off;
            int                   p;
            if (pos < 64'(icv_pkg::HEADER_BYTES))
            begin
                p = int'(pos);
                if (p < 8)       magic_acc[8*p +: 8]         = b;
                else if (p < 12) version_acc[8*(p-8) +: 8]   = b;
                else if (p < 20) declared_acc[8*(p-12) +: 8] = b;
                else if (p < 24) checksum_acc[8*(p-20) +: 8] = b;
            end
            else
            begin
                off      = pos - 64'(icv_pkg::HEADER_BYTES);
                hash_acc = (hash_acc ^ {24'd0, b}) * icv_pkg::HASH_PRIME;
                if (off < 64'(icv_pkg::COUNT_BYTES))
                begin
                    p = int'(off);
                    counts[p/4][8*(p%4) +: 8] = b;
                end
            end
            if (pos != '1) pos++;
            if (last)
            begin
                st          = judge();
                v.status    = st;
                v.tokens    = (st == icv_pkg::ST_OK) ? counts[0] : '0;
                v.dims      = (st == icv_pkg::ST_OK) ? counts[1] : '0;
                v.centroids = (st == icv_pkg::ST_OK) ? counts[2] : '0;
                v.stride    = (st == icv_pkg::ST_OK) ? counts[3] : '0;
                v.checksum  = (st == icv_pkg::ST_OK) ? checksum_acc : '0;
                pending     = {pending, v};
                clear_file();
            end
        endfunction

        function void check_result(file_verdict_t got);
            file_verdict_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: status %0d tok %h dim %h cen %h str %h sum %h",
                             got.status, got.tokens, got.dims, got.centroids, got.stride,
                             got.checksum);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: exp st %0d tok %h dim %h cen %h str %h sum %h",
                              " | got st %0d tok %h dim %h cen %h str %h sum %h"},
                             want.status, want.tokens, want.dims, want.centroids,
                             want.stride, want.checksum, got.status, got.tokens, got.dims,
                             got.centroids, got.stride, got.checksum);
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [icv_pkg::ADDR_W-1:0]  paddr;
    logic [63:0]                 pwdata;
    logic [63:0]                 prdata;
    logic                        pready;

    icv_in_if  stream_if ();
    icv_out_if result_if ();

    container_scoreboard sb;

    logic [7:0] file_img [$];     // bytes of the container being sent
    int         burst_left = 0;   // transfers left in the current sender burst
    int         bytes_sent = 0;
    int         files_sent = 0;
    bit         hold_request = 1'b0;
    int         hold_left = 0;
    rx_mode_t   rx_mode = RX_STEADY;
    int         mode_left = 0;

    index_container_validator_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream_if),
        .result  (result_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case a handshake never completes or a verdict never arrives.
    initial
    begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: check each transfer against the oldest verdict, then pick
    // the ready level for the next cycle. A hold request forces a long stall.
    always @(posedge clk)
    begin : result_side
        file_verdict_t got;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                got.status    = result_if.status;
                got.tokens    = result_if.token_count;
                got.dims      = result_if.dimension_count;
                got.centroids = result_if.centroid_count;
                got.stride    = result_if.token_stride_out;
                got.checksum  = result_if.checksum_out;
                sb.check_result(got);
            end
            if (hold_request && hold_left == 0)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (rx_mode)
                    RX_STEADY:    result_if.ready <= 1'b1;
                    RX_MOSTLY:    result_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:    result_if.ready <= ($urandom_range(0, 3) == 0);
                    RX_ALTERNATE: result_if.ready <= mode_left[1];
                    default:      result_if.ready <= 1'b1;
                endcase
            end
        end
    end

    // Byte count of a well-formed payload for the given counts.
    function automatic int fitted_len(logic [31:0] tok, logic [31:0] dim,
                                      logic [31:0] cen, logic [31:0] stride);
        return int'(container_scoreboard::layout_size(tok, dim, cen, stride));
    endfunction

    // Stream file_img out, last byte flagged. Bursts of random length with
    // random gaps; a zero gap lets consecutive bursts run back to back.
    task automatic send_file();
        int gap;
        foreach (file_img[i])
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    stream_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, 48);
            end
            burst_left--;
            stream_if.valid     <= 1'b1;
            stream_if.data_byte <= file_img[i];
            stream_if.last_byte <= (i == file_img.size() - 1);
            @(posedge clk);
            while (!stream_if.ready) @(posedge clk);
            sb.note_byte(file_img[i], i == file_img.size() - 1);
            bytes_sent++;
        end
        files_sent++;
    endtask

    task automatic send_noise(int n);
        file_img.delete();
        repeat (n) file_img = {file_img, 8'($urandom)};
        send_file();
    endtask

    // Build a container for the current register settings, spoil it as asked,
    // then send it.
    task automatic send_container(logic [31:0] tok, logic [31:0] dim, logic [31:0] cen,
                                  logic [31:0] stride, int plen, container_fault_t fault);
        logic [63:0]  mg;
        logic [31:0]  ver;
        logic [63:0]  decl;
        logic [31:0]  sum;
        logic [127:0] words;
        logic [7:0]   payload [$];
        int           cut;
        mg  = sb.magic_cfg;
        ver = sb.version_cfg;
        // Pad past the size the counts call for; length and checksum stay right.
        if (fault == FLT_SIZE) plen += $urandom_range(1, 4);
        words = {stride, cen, dim, tok};
        for (int i = 0; i < plen; i++)
            payload = {payload, (i < 16) ? words[8*i +: 8] : 8'($urandom)};
        sum = icv_pkg::HASH_BASIS;
        foreach (payload[i]) sum = (sum ^ {24'd0, payload[i]}) * icv_pkg::HASH_PRIME;
        decl = 64'(plen);
        case (fault)
            FLT_MAGIC:    mg   ^= 64'd1 << $urandom_range(0, 63);
            FLT_VERSION:  ver  ^= 32'd1 << $urandom_range(0, 31);
            FLT_LENGTH:   decl ^= 64'd1 << $urandom_range(0, 63);
            FLT_CHECKSUM: sum  ^= 32'd1 << $urandom_range(0, 31);
            default:      ;
        endcase
        file_img.delete();
        for (int i = 0; i < icv_pkg::HEADER_BYTES; i++)
        begin
            if (i < 8)       file_img = {file_img, mg[8*i +: 8]};
            else if (i < 12) file_img = {file_img, ver[8*(i-8) +: 8]};
            else if (i < 20) file_img = {file_img, decl[8*(i-12) +: 8]};
            else if (i < 24) file_img = {file_img, sum[8*(i-20) +: 8]};
            else             file_img = {file_img, 8'($urandom)};
        end
        file_img = {file_img, payload};
        if (fault == FLT_TRUNC)
        begin
            cut = $urandom_range(1, file_img.size() - 1);
            repeat (cut) void'(file_img.pop_back());
        end
        send_file();
    endtask

    // Drop valid and wait until every verdict has come back, plus the
    // pipeline depth, so the block is idle.
    task automatic settle();
        stream_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Two-phase register write: setup, then access; it lands when pready is high.
    task automatic write_reg(logic [icv_pkg::ADDR_W-1:0] addr, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == icv_pkg::ADDR_MAGIC) sb.magic_cfg = value;
        else                             sb.version_cfg = value[31:0];
    endtask

    task automatic configure(logic [63:0] mg, logic [63:0] ver);
        settle();
        write_reg(icv_pkg::ADDR_MAGIC, mg);
        write_reg(icv_pkg::ADDR_VERSION, ver);
    endtask

    // Stall the result side for a long stretch while tiny files keep coming,
    // so the inner queue fills and the stream side has to back off.
    task automatic squeeze_output();
        hold_request = 1'b1;
        repeat (12) send_noise($urandom_range(1, 3));
    endtask

    initial
    begin : stimulus
        logic [31:0] tok;
        logic [31:0] dim;
        logic [31:0] cen;
        logic [31:0] stride;
        int          pick;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        stream_if.valid     = 1'b0;
        stream_if.data_byte = '0;
        stream_if.last_byte = 1'b0;
        result_if.ready     = 1'b0;
        sb = new();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files: at least one per status code, with reset register values.
        send_noise(1);                                        // lone byte, no header
        send_noise(icv_pkg::HEADER_BYTES - 1);                // header one byte short
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_NONE);
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_MAGIC);
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_VERSION);
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_LENGTH);
        send_container(0, 0, 0, 0, 0, FLT_NONE);              // empty payload
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_CHECKSUM);
        send_container(5, 1, 1, 1, 9, FLT_NONE);              // too short for the counts
        send_container(3, 2, 1, 4, fitted_len(3, 2, 1, 4), FLT_SIZE);
        // Size terms wrap to zero modulo 2^64, leaving only the count words.
        send_container(32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16, FLT_NONE);

        // Register extremes; the upper half of the version word must be dropped.
        configure(64'd0, 64'd0);
        send_container(1, 1, 1, 1, fitted_len(1, 1, 1, 1), FLT_NONE);
        configure('1, '1);
        send_container(2, 0, 2, 3, fitted_len(2, 0, 2, 3), FLT_NONE);
        configure(icv_pkg::MAGIC_RESET, 64'(icv_pkg::VERSION_RESET));

        squeeze_output();

        // Random files: about half well formed with random content, the rest
        // spoiled, cut short, or plain noise.
        bytes_sent = 0;
        files_sent = 0;
        while (bytes_sent < RANDOM_BYTES || files_sent < RANDOM_FILES)
        begin
            if (files_sent % 8 == 7)
            begin
                configure(($urandom_range(0, 2) == 0) ? icv_pkg::MAGIC_RESET
                                                      : {32'($urandom), 32'($urandom)},
                          ($urandom_range(0, 2) == 0)
                              ? {32'($urandom), icv_pkg::VERSION_RESET}
                              : {32'($urandom), 32'($urandom)});
            end
            if (files_sent == RANDOM_FILES / 2) squeeze_output();

            tok    = $urandom_range(0, 8);
            dim    = $urandom_range(0, 4);
            cen    = $urandom_range(0, 3);
            stride = $urandom_range(0, 8);
            case ($urandom_range(0, 9))
                0:
                begin
                    // Centroid terms that wrap to zero.
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            cen = 32'h8000_0000;
                            dim = 32'h7FFF_FFFF;
                        end
                        1:
                        begin
                            cen = 32'h8000_0000;
                            dim = 32'hFFFF_FFFF;
                        end
                        2:
                        begin
                            cen = 32'h4000_0000;
                            dim = 32'hFFFF_FFFF;
                        end
                        default:
                        begin
                            cen = 32'hC000_0000;
                            dim = 32'hFFFF_FFFF;
                        end
                    endcase
                end
                1:
                begin
                    tok    = $urandom;
                    stride = 32'd0;
                end
                2:
                begin
                    stride = $urandom;
                    tok    = 32'd0;
                end
                default: ;
            endcase

            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_container(tok, dim, cen, stride, fitted_len(tok, dim, cen, stride),
                               FLT_NONE);
            else if (pick < 75)
                send_container(tok, dim, cen, stride, fitted_len(tok, dim, cen, stride),
                               container_fault_t'($urandom_range(FLT_MAGIC, FLT_TRUNC)));
            else if (pick < 85)
                send_container(tok, dim, cen, stride,
                               $urandom_range(0, icv_pkg::COUNT_BYTES - 1), FLT_NONE);
            else
                send_noise($urandom_range(1, 90));
        end

        // Drain, give the pipeline time to show any stray transfer, then report.
        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
